### hdl/time_of_day_add_balance_unit_macros.svh
// Assertion macros shared by the time-of-day adder modules.
`ifndef TIME_OF_DAY_ADD_BALANCE_UNIT_MACROS_SVH
`define TIME_OF_DAY_ADD_BALANCE_UNIT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define TODAB_ASSERT(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("todab assertion failed");

// A consequence that must hold in the same cycle as its antecedent.
`define TODAB_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("todab assertion failed");

`endif

### hdl/todab_pkg.sv
// Shared constants and types of the time-of-day adder.
package todab_pkg;

  localparam int unsigned DELTA_BITS_DEF = 64;
  localparam int unsigned DELTA_W        = 64;

  localparam int unsigned HOUR_W = 5;
  localparam int unsigned MIN_W  = 6;
  localparam int unsigned SEC_W  = 6;
  localparam int unsigned SUB_W  = 10;
  localparam int unsigned DAY_W  = 18;

  localparam int unsigned SEC_PER_MIN  = 60;
  localparam int unsigned SEC_PER_HOUR = 3600;

  localparam logic [63:0] NS_PER_US   = 64'd1000;
  localparam logic [63:0] NS_PER_MS   = 64'd1000000;
  localparam logic [63:0] NS_PER_SEC  = 64'd1000000000;
  localparam logic [63:0] NS_PER_MIN  = 64'd60000000000;
  localparam logic [63:0] NS_PER_HOUR = 64'd3600000000000;
  localparam logic [63:0] NS_PER_DAY  = 64'd86400000000000;

  // One day is 2^16 times an odd constant, so the day split works on the upper bits.
  localparam int unsigned DAY_LO_W = 16;
  localparam logic [63:0] DAY_ODD  = NS_PER_DAY >> DAY_LO_W;

  // Widths of the start-time partial sums and of the biased total.
  localparam int unsigned SECS_W  = 17;
  localparam int unsigned SUBNS_W = 30;
  localparam int unsigned START_W = 47;
  localparam int unsigned SUM_W   = 65;

  // Adding 2^17 days keeps the total non-negative; the day count is then biased by 2^17.
  localparam logic [SUM_W-1:0] DAY_BIAS = SUM_W'(NS_PER_DAY) << (DAY_W - 1);

  // Fields that travel alongside the division steps.
  typedef struct packed {
    logic [DAY_LO_W-1:0] lo;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MIN_W-1:0]    minute;
    logic [SEC_W-1:0]    second;
    logic [SUB_W-1:0]    milli;
  } todab_word_t;

endpackage

### hdl/todab_front.sv
// Front end: weights the start time, sign-extends the offset and forms the biased total.
`include "time_of_day_add_balance_unit_macros.svh"

module todab_front import todab_pkg::*; #(
  parameter int unsigned DELTA_BITS = DELTA_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [HOUR_W-1:0]            hour_i,
  input  logic [MIN_W-1:0]             minute_i,
  input  logic [SEC_W-1:0]             second_i,
  input  logic [SUB_W-1:0]             milli_i,
  input  logic [SUB_W-1:0]             micro_i,
  input  logic [SUB_W-1:0]             nano_i,
  input  logic [DELTA_W-1:0]           delta_i,
  output logic                         valid_o,
  output logic [SUM_W-DAY_LO_W-1:0]    hi_o,
  output logic [DAY_LO_W-1:0]          lo_o
);

  localparam int unsigned DB = (DELTA_BITS < DELTA_W) ? DELTA_BITS : DELTA_W;

  logic [2:0]             vld_q;
  logic [SECS_W-1:0]      secs_d, secs_q;
  logic [SUBNS_W-1:0]     subns_d, subns_q;
  logic [DB-1:0]          delta_q;
  logic [START_W-1:0]     start_d, start_q;
  logic [SUM_W-1:0]       dext;
  logic [SUM_W-1:0]       dbias_d, dbias_q;
  logic [SUM_W-1:0]       sum_d, sum_q;

  always_comb begin
    secs_d  = SECS_W'(hour_i) * SECS_W'(SEC_PER_HOUR)
            + SECS_W'(minute_i) * SECS_W'(SEC_PER_MIN)
            + SECS_W'(second_i);
    subns_d = SUBNS_W'(milli_i) * SUBNS_W'(NS_PER_MS)
            + SUBNS_W'(micro_i) * SUBNS_W'(NS_PER_US)
            + SUBNS_W'(nano_i);
  end

  always_comb begin
    dext    = {{(SUM_W - DB){delta_q[DB-1]}}, delta_q};
    start_d = START_W'(secs_q) * START_W'(NS_PER_SEC) + START_W'(subns_q);
    dbias_d = dext + DAY_BIAS;
    sum_d   = SUM_W'(start_q) + dbias_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    secs_q  <= secs_d;
    subns_q <= subns_d;
    delta_q <= delta_i[DB-1:0];
    start_q <= start_d;
    dbias_q <= dbias_d;
    sum_q   <= sum_d;
  end

  assign valid_o = vld_q[2];
  assign hi_o    = sum_q[SUM_W-1:DAY_LO_W];
  assign lo_o    = sum_q[DAY_LO_W-1:0];

endmodule

### hdl/todab_divstep.sv
// One floor divide-and-remainder step by a constant, two register stages deep.
`include "time_of_day_add_balance_unit_macros.svh"

module todab_divstep import todab_pkg::*; #(
  parameter int unsigned X_W     = 47,
  parameter logic [63:0] DIVISOR = NS_PER_HOUR,
  parameter int unsigned Q_W     = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [X_W-1:0]                x_i,
  input  todab_word_t                   word_i,
  output logic                          valid_o,
  output logic [Q_W-1:0]                quot_o,
  output logic [$clog2(DIVISOR)-1:0]    rem_o,
  output todab_word_t                   word_o
);

  localparam int unsigned R_W   = $clog2(DIVISOR);
  // The estimate uses the bits above SH; 2^SH stays below a quarter of the divisor.
  localparam int unsigned SH    = R_W - 3;
  localparam int unsigned XS_W  = X_W - SH;
  localparam int unsigned T_SH  = XS_W + 2;
  localparam logic [63:0] RECIP = (64'd1 << (SH + T_SH)) / DIVISOR;
  localparam int unsigned RC_W  = $clog2(RECIP + 64'd1);
  localparam int unsigned P_W   = XS_W + RC_W;

  logic [P_W-1:0]   prod;
  logic [Q_W-1:0]   qe_d, qe_q;
  logic [X_W-1:0]   xa_q;
  todab_word_t      worda_q;
  logic             va_q;

  logic [R_W:0]     r0;
  logic [R_W+1:0]   r1;
  logic [Q_W-1:0]   q_d, q_q;
  logic [R_W-1:0]   r_d, r_q;
  todab_word_t      wordb_q;
  logic             vb_q;

  // The estimate is never above the true quotient and at most one below it.
  always_comb begin
    prod = P_W'(x_i[X_W-1:SH]) * P_W'(RECIP[RC_W-1:0]);
    qe_d = Q_W'(prod >> T_SH);
  end

  // The remainder lies below twice the divisor, so only its low bits are needed.
  always_comb begin
    r0  = xa_q[R_W:0] - (R_W + 1)'((R_W + 1)'(qe_q) * DIVISOR[R_W:0]);
    r1  = {1'b0, r0} - (R_W + 2)'(DIVISOR);
    if (!r1[R_W+1]) begin
      q_d = qe_q + Q_W'(1);
      r_d = r1[R_W-1:0];
    end else begin
      q_d = qe_q;
      r_d = r0[R_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    qe_q    <= qe_d;
    xa_q    <= x_i;
    worda_q <= word_i;
    q_q     <= q_d;
    r_q     <= r_d;
    wordb_q <= worda_q;
  end

  assign valid_o = vb_q;
  assign quot_o  = q_q;
  assign rem_o   = r_q;
  assign word_o  = wordb_q;

  `TODAB_ASSERT_IMP(a_est_not_high, clk_i, rst_ni, va_q, 64'(xa_q) >= 64'(qe_q) * DIVISOR)
  `TODAB_ASSERT_IMP(a_est_close, clk_i, rst_ni, va_q, (64'(xa_q) - 64'(qe_q) * DIVISOR) < (DIVISOR << 1))
  `TODAB_ASSERT_IMP(a_rem_range, clk_i, rst_ni, vb_q, 64'(r_q) < DIVISOR)

endmodule

### hdl/time_of_day_add_balance_unit.sv
// An accepted start passes through the front end and the six divide steps to the done_o strobe of its word.
// Throughput: one word per cycle; the pipeline never stalls and the receiver cannot hold it off.
// Depth is set by the front-end adders (3 stages) and six divide steps of 2 stages each.
// Reset clears every valid bit; busy is high in reset and in the first cycle after it,
// and low from then on.
`include "time_of_day_add_balance_unit_macros.svh"

module time_of_day_add_balance_unit import todab_pkg::*; #(
  parameter int unsigned DELTA_BITS = DELTA_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [HOUR_W-1:0]    hour_in_i,
  input  logic [MIN_W-1:0]     minute_in_i,
  input  logic [SEC_W-1:0]     second_in_i,
  input  logic [SUB_W-1:0]     milli_in_i,
  input  logic [SUB_W-1:0]     micro_in_i,
  input  logic [SUB_W-1:0]     nano_in_i,
  input  logic [DELTA_W-1:0]   delta_ns_i,
  output logic                 done_o,
  output logic [HOUR_W-1:0]    hour_out_o,
  output logic [MIN_W-1:0]     minute_out_o,
  output logic [SEC_W-1:0]     second_out_o,
  output logic [SUB_W-1:0]     milli_out_o,
  output logic [SUB_W-1:0]     micro_out_o,
  output logic [SUB_W-1:0]     nano_out_o,
  output logic [DAY_W-1:0]     day_carry_o
);

  localparam int unsigned LATENCY = 15;
  localparam int unsigned HI_W    = SUM_W - DAY_LO_W;
  localparam int unsigned RDAY_W  = $clog2(DAY_ODD);
  localparam int unsigned TOD_W   = RDAY_W + DAY_LO_W;
  localparam int unsigned RH_W    = $clog2(NS_PER_HOUR);
  localparam int unsigned RM_W    = $clog2(NS_PER_MIN);
  localparam int unsigned RS_W    = $clog2(NS_PER_SEC);
  localparam int unsigned RMS_W   = $clog2(NS_PER_MS);
  localparam int unsigned RUS_W   = $clog2(NS_PER_US);

  logic              busy_d, busy_q;
  logic              accept;

  logic              fr_valid;
  logic [HI_W-1:0]   fr_hi;
  logic [DAY_LO_W-1:0] fr_lo;

  todab_word_t       w_day_in, w_day_out;
  logic              v_day;
  logic [DAY_W-1:0]  q_day;
  logic [RDAY_W-1:0] r_day;

  todab_word_t       w_h_in, w_h_out;
  logic              v_h;
  logic [HOUR_W-1:0] q_h;
  logic [RH_W-1:0]   r_h;
  logic [TOD_W-1:0]  tod;

  todab_word_t       w_m_in, w_m_out;
  logic              v_m;
  logic [MIN_W-1:0]  q_m;
  logic [RM_W-1:0]   r_m;

  todab_word_t       w_s_in, w_s_out;
  logic              v_s;
  logic [SEC_W-1:0]  q_s;
  logic [RS_W-1:0]   r_s;

  todab_word_t       w_ms_in, w_ms_out;
  logic              v_ms;
  logic [SUB_W-1:0]  q_ms;
  logic [RMS_W-1:0]  r_ms;

  todab_word_t       w_us_in, w_us_out;
  logic              v_us;
  logic [SUB_W-1:0]  q_us;
  logic [RUS_W-1:0]  r_us;

  assign busy_d = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= busy_d;
    end
  end

  assign busy   = busy_q;
  assign accept = start && !busy_q;

  todab_front #(
    .DELTA_BITS (DELTA_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .hour_i   (hour_in_i),
    .minute_i (minute_in_i),
    .second_i (second_in_i),
    .milli_i  (milli_in_i),
    .micro_i  (micro_in_i),
    .nano_i   (nano_in_i),
    .delta_i  (delta_ns_i),
    .valid_o  (fr_valid),
    .hi_o     (fr_hi),
    .lo_o     (fr_lo)
  );

  always_comb begin
    w_day_in    = '0;
    w_day_in.lo = fr_lo;
  end

  // Whole days: the biased total divided by one day, done on the bits above 2^16.
  todab_divstep #(
    .X_W     (HI_W),
    .DIVISOR (DAY_ODD),
    .Q_W     (DAY_W)
  ) u_day (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .x_i     (fr_hi),
    .word_i  (w_day_in),
    .valid_o (v_day),
    .quot_o  (q_day),
    .rem_o   (r_day),
    .word_o  (w_day_out)
  );

  // Removing the bias of 2^17 days flips the top bit of the day count.
  always_comb begin
    w_h_in     = w_day_out;
    w_h_in.day = {~q_day[DAY_W-1], q_day[DAY_W-2:0]};
    tod        = {r_day, w_day_out.lo};
  end

  todab_divstep #(
    .X_W     (TOD_W),
    .DIVISOR (NS_PER_HOUR),
    .Q_W     (HOUR_W)
  ) u_hour (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_day),
    .x_i     (tod),
    .word_i  (w_h_in),
    .valid_o (v_h),
    .quot_o  (q_h),
    .rem_o   (r_h),
    .word_o  (w_h_out)
  );

  always_comb begin
    w_m_in      = w_h_out;
    w_m_in.hour = q_h;
  end

  todab_divstep #(
    .X_W     (RH_W),
    .DIVISOR (NS_PER_MIN),
    .Q_W     (MIN_W)
  ) u_min (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_h),
    .x_i     (r_h),
    .word_i  (w_m_in),
    .valid_o (v_m),
    .quot_o  (q_m),
    .rem_o   (r_m),
    .word_o  (w_m_out)
  );

  always_comb begin
    w_s_in        = w_m_out;
    w_s_in.minute = q_m;
  end

  todab_divstep #(
    .X_W     (RM_W),
    .DIVISOR (NS_PER_SEC),
    .Q_W     (SEC_W)
  ) u_sec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_m),
    .x_i     (r_m),
    .word_i  (w_s_in),
    .valid_o (v_s),
    .quot_o  (q_s),
    .rem_o   (r_s),
    .word_o  (w_s_out)
  );

  always_comb begin
    w_ms_in        = w_s_out;
    w_ms_in.second = q_s;
  end

  todab_divstep #(
    .X_W     (RS_W),
    .DIVISOR (NS_PER_MS),
    .Q_W     (SUB_W)
  ) u_milli (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_s),
    .x_i     (r_s),
    .word_i  (w_ms_in),
    .valid_o (v_ms),
    .quot_o  (q_ms),
    .rem_o   (r_ms),
    .word_o  (w_ms_out)
  );

  always_comb begin
    w_us_in       = w_ms_out;
    w_us_in.milli = q_ms;
  end

  todab_divstep #(
    .X_W     (RMS_W),
    .DIVISOR (NS_PER_US),
    .Q_W     (SUB_W)
  ) u_micro (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_ms),
    .x_i     (r_ms),
    .word_i  (w_us_in),
    .valid_o (v_us),
    .quot_o  (q_us),
    .rem_o   (r_us),
    .word_o  (w_us_out)
  );

  // The last step leaves micro and nano on its own outputs; the rest ride in the word.
  assign done_o       = v_us;
  assign hour_out_o   = w_us_out.hour;
  assign minute_out_o = w_us_out.minute;
  assign second_out_o = w_us_out.second;
  assign milli_out_o  = w_us_out.milli;
  assign micro_out_o  = q_us;
  assign nano_out_o   = r_us;
  assign day_carry_o  = w_us_out.day;

  `TODAB_ASSERT(a_latency, clk_i, rst_ni, done_o == $past(start && !busy, LATENCY))
  `TODAB_ASSERT_IMP(a_hms_range, clk_i, rst_ni, done_o, hour_out_o <= 5'd23 && minute_out_o <= 6'd59 && second_out_o <= 6'd59)
  `TODAB_ASSERT_IMP(a_sub_range, clk_i, rst_ni, done_o, milli_out_o <= 10'd999 && micro_out_o <= 10'd999 && nano_out_o <= 10'd999)

endmodule

### bench/time_of_day_add_balance_unit_tb.sv
// Self-checking testbench for the time-of-day adder with day carry.
module time_of_day_add_balance_unit_tb;
  import todab_pkg::*;

  localparam int unsigned OFFSET_BITS = (DELTA_BITS_DEF >= 64) ? 64 : DELTA_BITS_DEF;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_WORDS = 1800;

  typedef struct {
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic [SUB_W-1:0]   milli;
    logic [SUB_W-1:0]   micro;
    logic [SUB_W-1:0]   nano;
    logic [DELTA_W-1:0] delta;
    int unsigned        idle_pct;
    bit                 drain;
  } tod_req_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [SUB_W-1:0]  milli;
    logic [SUB_W-1:0]  micro;
    logic [SUB_W-1:0]  nano;
    logic [DAY_W-1:0]  days;
  } tod_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [HOUR_W-1:0]  hour_in = '0;
  logic [MIN_W-1:0]   minute_in = '0;
  logic [SEC_W-1:0]   second_in = '0;
  logic [SUB_W-1:0]   milli_in = '0;
  logic [SUB_W-1:0]   micro_in = '0;
  logic [SUB_W-1:0]   nano_in = '0;
  logic [DELTA_W-1:0] delta_ns = '0;
  logic               done_o;
  logic [HOUR_W-1:0]  hour_out;
  logic [MIN_W-1:0]   minute_out;
  logic [SEC_W-1:0]   second_out;
  logic [SUB_W-1:0]   milli_out;
  logic [SUB_W-1:0]   micro_out;
  logic [SUB_W-1:0]   nano_out;
  logic [DAY_W-1:0]   day_carry;

  tod_req_t    time_words[$];
  tod_res_t    balanced_times[$];
  tod_req_t    driven_word;
  tod_res_t    got_time;
  tod_res_t    want_time;
  bit          launch;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  time_of_day_add_balance_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .hour_in_i    (hour_in),
    .minute_in_i  (minute_in),
    .second_in_i  (second_in),
    .milli_in_i   (milli_in),
    .micro_in_i   (micro_in),
    .nano_in_i    (nano_in),
    .delta_ns_i   (delta_ns),
    .done_o       (done_o),
    .hour_out_o   (hour_out),
    .minute_out_o (minute_out),
    .second_out_o (second_out),
    .milli_out_o  (milli_out),
    .micro_out_o  (micro_out),
    .nano_out_o   (nano_out),
    .day_carry_o  (day_carry)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Adds the offset to the start time exactly in 128 bits, then splits by floor division.
  function automatic tod_res_t predict_balanced(tod_req_t w);
    logic signed [63:0]  offset;
    logic [63:0]         start_ns;
    logic signed [127:0] total;
    logic signed [127:0] day_len;
    logic signed [127:0] days;
    logic signed [127:0] rem;
    logic [63:0]         tod;
    tod_res_t            res;
    offset = $signed(w.delta << (64 - OFFSET_BITS)) >>> (64 - OFFSET_BITS);
    start_ns = w.hour * NS_PER_HOUR + w.minute * NS_PER_MIN + w.second * NS_PER_SEC
             + w.milli * NS_PER_MS + w.micro * NS_PER_US + 64'(w.nano);
    total = offset;
    total = total + $signed({64'd0, start_ns});
    day_len = $signed({64'd0, NS_PER_DAY});
    days = total / day_len;
    rem = total % day_len;
    if (rem < 0) begin
      days = days - 1;
      rem = rem + day_len;
    end
    tod = rem[63:0];
    res.hour = HOUR_W'(tod / NS_PER_HOUR);
    res.minute = MIN_W'((tod / NS_PER_MIN) % 60);
    res.second = SEC_W'((tod / NS_PER_SEC) % 60);
    res.milli = SUB_W'((tod / NS_PER_MS) % 1000);
    res.micro = SUB_W'((tod / NS_PER_US) % 1000);
    res.nano = SUB_W'(tod % 1000);
    res.days = days[DAY_W-1:0];
    return res;
  endfunction

  function automatic tod_req_t time_word(logic [HOUR_W-1:0] h, logic [MIN_W-1:0] m,
                                         logic [SEC_W-1:0] s, logic [SUB_W-1:0] ms,
                                         logic [SUB_W-1:0] us, logic [SUB_W-1:0] ns,
                                         logic [DELTA_W-1:0] d);
    tod_req_t w;
    w.hour = h;
    w.minute = m;
    w.second = s;
    w.milli = ms;
    w.micro = us;
    w.nano = ns;
    w.delta = d;
    w.idle_pct = 29;
    w.drain = 1'b0;
    return w;
  endfunction

  // Mostly valid start times; now and then a field takes any value its width allows.
  function automatic tod_req_t random_word(int unsigned idle_pct);
    tod_req_t           w;
    logic [DELTA_W-1:0] mag;
    logic signed [63:0] k;
    w.hour = ($urandom_range(0, 9) == 0) ? HOUR_W'($urandom) : HOUR_W'($urandom_range(0, 23));
    w.minute = ($urandom_range(0, 9) == 0) ? MIN_W'($urandom) : MIN_W'($urandom_range(0, 59));
    w.second = ($urandom_range(0, 9) == 0) ? SEC_W'($urandom) : SEC_W'($urandom_range(0, 59));
    w.milli = ($urandom_range(0, 9) == 0) ? SUB_W'($urandom) : SUB_W'($urandom_range(0, 999));
    w.micro = ($urandom_range(0, 9) == 0) ? SUB_W'($urandom) : SUB_W'($urandom_range(0, 999));
    w.nano = ($urandom_range(0, 9) == 0) ? SUB_W'($urandom) : SUB_W'($urandom_range(0, 999));
    case ($urandom_range(0, 9))
      0, 1, 2: mag = {$urandom, $urandom};
      3, 4, 5: mag = {14'd0, 18'($urandom), $urandom};
      6: begin
        k = $signed(64'(18'($urandom))) - 64'sd131072;
        mag = k * $signed(NS_PER_DAY) + $signed(64'($urandom_range(0, 2000))) - 64'sd1000;
      end
      7: mag = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1 << 20));
      default: mag = {24'd0, 8'($urandom), $urandom};
    endcase
    w.delta = $urandom_range(0, 1) ? (~mag + 64'd1) : mag;
    w.idle_pct = idle_pct;
    w.drain = 1'b0;
    return w;
  endfunction

  // Driver: a word stays on the inputs until busy lets it through.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        balanced_times.push_back(predict_balanced(driven_word));
      end
      if (!(start && busy)) begin
        launch = 1'b0;
        if (time_words.size() > 0) begin
          if (!(time_words[0].drain && balanced_times.size() > 0)) begin
            launch = ($urandom_range(0, 99) >= time_words[0].idle_pct);
          end
        end
        if (launch) begin
          driven_word = time_words.pop_front();
          hour_in <= driven_word.hour;
          minute_in <= driven_word.minute;
          second_in <= driven_word.second;
          milli_in <= driven_word.milli;
          micro_in <= driven_word.micro;
          nano_in <= driven_word.nano;
          delta_ns <= driven_word.delta;
        end
        start <= launch;
      end
    end
  end

  // Monitor: every done_o strobe must match the oldest predicted time.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (balanced_times.size() == 0) begin
        $error("unexpected result word: no prediction pending");
        mismatch_count <= mismatch_count + 1;
      end else begin
        want_time = balanced_times.pop_front();
        got_time = '{hour_out, minute_out, second_out, milli_out, micro_out, nano_out,
                     day_carry};
        if (got_time != want_time) begin
          mismatch_count <= mismatch_count + 1;
          if (got_time.hour != want_time.hour)
            $error("hour_out: expected %0d, actual %0d", want_time.hour, got_time.hour);
          if (got_time.minute != want_time.minute)
            $error("minute_out: expected %0d, actual %0d", want_time.minute, got_time.minute);
          if (got_time.second != want_time.second)
            $error("second_out: expected %0d, actual %0d", want_time.second, got_time.second);
          if (got_time.milli != want_time.milli)
            $error("milli_out: expected %0d, actual %0d", want_time.milli, got_time.milli);
          if (got_time.micro != want_time.micro)
            $error("micro_out: expected %0d, actual %0d", want_time.micro, got_time.micro);
          if (got_time.nano != want_time.nano)
            $error("nano_out: expected %0d, actual %0d", want_time.nano, got_time.nano);
          if (got_time.days != want_time.days)
            $error("day_carry: expected %0d, actual %0d", $signed(want_time.days),
                   $signed(got_time.days));
        end
      end
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    // Day boundaries, both offset extremes and start fields above their ranges.
    time_words.push_back(time_word(0, 0, 0, 0, 0, 0, 64'd0));
    time_words.push_back(time_word(23, 59, 59, 999, 999, 999, 64'd0));
    time_words.push_back(time_word(23, 59, 59, 999, 999, 999, 64'd1));
    time_words.push_back(time_word(0, 0, 0, 0, 0, 0, -64'sd1));
    time_words.push_back(time_word(0, 0, 0, 0, 0, 0, NS_PER_DAY));
    time_words.push_back(time_word(0, 0, 0, 0, 0, 0, -NS_PER_DAY));
    time_words.push_back(time_word(0, 0, 0, 0, 0, 0, NS_PER_DAY - 64'd1));
    time_words.push_back(time_word(0, 0, 0, 0, 0, 1, -NS_PER_DAY - 64'd1));
    time_words.push_back(time_word(0, 0, 0, 0, 0, 0, 64'h8000_0000_0000_0000));
    time_words.push_back(time_word(0, 0, 0, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF));
    time_words.push_back(time_word('1, '1, '1, '1, '1, '1, 64'h7FFF_FFFF_FFFF_FFFF));
    time_words.push_back(time_word('1, '1, '1, '1, '1, '1, 64'h8000_0000_0000_0000));
    time_words.push_back(time_word(23, 59, 59, 999, 999, 999, 64'h8000_0000_0000_0000));
    time_words.push_back(time_word(31, 0, 0, 0, 0, 0, 64'd0));
    time_words.push_back(time_word(0, 63, 0, 0, 0, 0, 64'd0));
    time_words.push_back(time_word(0, 0, 63, 0, 0, 0, 64'd0));
    time_words.push_back(time_word(0, 0, 0, 1023, 1023, 1023, 64'd0));
    time_words.push_back(time_word('1, '1, '1, '1, '1, '1, -64'sd1));
    time_words.push_back(time_word(12, 30, 30, 500, 500, 500, NS_PER_DAY * 64'd106751));
    time_words.push_back(time_word(12, 30, 30, 500, 500, 500, -(NS_PER_DAY * 64'd106752)));
    // Sender idles with a chance of 29 percent, then 86, and finally never.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      time_words.push_back(random_word((i < RANDOM_WORDS / 3) ? 29 :
                                       (i < 2 * RANDOM_WORDS / 3) ? 86 : 0));
      if (i == RANDOM_WORDS / 3 || i == 2 * RANDOM_WORDS / 3) begin
        time_words[$].drain = 1'b1;
      end
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (time_words.size() > 0 || start || balanced_times.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### time_of_day_add_balance_unit.f
+incdir+hdl
hdl/todab_pkg.sv
hdl/todab_front.sv
hdl/todab_divstep.sv
hdl/time_of_day_add_balance_unit.sv
bench/time_of_day_add_balance_unit_tb.sv
